// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the dispatcher.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/sjfd_pkg.sv
// Package of the shortest-job-first dispatcher: sizes, codes and job types.
// Depends on nothing; used by every module of the dispatcher.
package sjfd_pkg;

    localparam int READY_DEPTH = 64;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int EVENT_W = 2;

    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam logic [EVENT_W-1:0] EV_NONE     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DISPATCH = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DROP     = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  arrival;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry data;
    } t_job;

    // Chain-wide command for an update cycle.
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

    localparam t_job JOB_EMPTY = '0;

endpackage

// File: rtl/core/sjfd_cell.sv
// One cell of the sorted ready chain: holds a single waiting job.
// Depends on sjfd_pkg; instantiated in a row by the dispatcher top level.
module sjfd_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sjfd_pkg::t_cell_ctl i_ctl,
    input  sjfd_pkg::t_job      i_new,
    input  sjfd_pkg::t_job      i_prev_job,
    input  logic                i_prev_before,
    input  sjfd_pkg::t_job      i_next_job,
    output sjfd_pkg::t_job      o_job,
    output logic                o_before
);
    import sjfd_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_entry r_data;
    t_entry n_data;

    // The new job goes ahead of this cell's job when the cell is empty, its
    // burst is shorter, or the burst ties, both arrived this tick and its id
    // is lower. Any job that arrived on an earlier tick has waited longer.
    assign o_before = !r_valid
                    || (i_new.data.burst < r_data.burst)
                    || ((i_new.data.burst == r_data.burst)
                        && (i_new.data.arrival == r_data.arrival)
                        && (i_new.data.id < r_data.id));

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        priority if (i_ctl.pop) begin
            n_valid = i_next_job.valid;
            n_data  = i_next_job.data;
        end else if (i_ctl.ins && o_before) begin
            if (i_prev_before) begin
                n_valid = i_prev_job.valid;
                n_data  = i_prev_job.data;
            end else begin
                n_valid = 1'b1;
                n_data  = i_new.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_job = '{valid: r_valid, data: r_data};

endmodule

// File: rtl/core/shortest_job_first_dispatcher_top.sv
// Top level of the non-preemptive shortest-job-first dispatcher.
// Depends on sjfd_pkg and sjfd_cell.
//
// A request is taken at a rising edge where start is high and busy is low.
// i_action selects an arrival (i_job_id and i_burst_length are stored with
// the current tick) or one time tick. Every request yields exactly one
// result, shown for a single cycle with o_result_valid high. The receiver
// cannot stall, so the result must be captured in that cycle.
//
// busy is high in the cycle after a request is taken. That is the
// update cycle of the cell chain, which may insert a job or shift out
// the head job. The result strobe follows in the next cycle, when busy is
// already low again. A new request is taken only while busy is low, and
// the result registers are loaded at the end of the update cycle.
//
// The ready jobs live in a row of READY_DEPTH cells kept in service order
// (shortest burst, then longest wait, then lower id). The store is full when
// the last cell holds a job. A synchronous active-low reset empties the
// chain, zeroes the current tick and the remaining service count, and clears
// busy and the strobe.
module shortest_job_first_dispatcher_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [sjfd_pkg::ID_W-1:0]    i_job_id,
    input  logic [sjfd_pkg::BURST_W-1:0] i_burst_length,
    output logic                         o_result_valid,
    output logic [sjfd_pkg::EVENT_W-1:0] o_event_res,
    output logic [sjfd_pkg::ID_W-1:0]    o_out_job_id,
    output logic [sjfd_pkg::TIME_W-1:0]  o_start_time,
    output logic [sjfd_pkg::TIME_W-1:0]  o_completion_time,
    output logic [sjfd_pkg::TIME_W-1:0]  o_waiting_time,
    output logic [sjfd_pkg::TIME_W-1:0]  o_turnaround_time
);
    import sjfd_pkg::*;

    // Control state.
    logic               r_busy;
    logic               r_result_valid;
    logic [TIME_W-1:0]  r_tick;
    logic [TIME_W-1:0]  n_tick;
    logic [BURST_W-1:0] r_remaining;
    logic [BURST_W-1:0] n_remaining;

    // Captured request.
    logic               r_req_action;
    logic [ID_W-1:0]    r_req_id;
    logic [BURST_W-1:0] r_req_burst;

    // Result registers.
    logic [EVENT_W-1:0] r_event;
    logic [EVENT_W-1:0] n_event;
    logic [ID_W-1:0]    r_out_id;
    logic [ID_W-1:0]    n_out_id;
    logic [TIME_W-1:0]  r_start;
    logic [TIME_W-1:0]  n_start;
    logic [TIME_W-1:0]  r_done;
    logic [TIME_W-1:0]  n_done;
    logic [TIME_W-1:0]  r_wait;
    logic [TIME_W-1:0]  n_wait;
    logic [TIME_W-1:0]  r_turn;
    logic [TIME_W-1:0]  n_turn;

    // Chain wiring.
    t_job      w_job    [READY_DEPTH];
    logic      w_before [READY_DEPTH];
    t_cell_ctl w_ctl;
    t_job      w_new;

    logic              w_accept;
    logic              w_full;
    logic              w_dispatch;
    logic [TIME_W-1:0] w_head_done;

    assign w_accept = start && !r_busy;

    assign w_new = '{valid: 1'b1,
                     data: '{id: r_req_id, burst: r_req_burst, arrival: r_tick}};

    assign w_full     = w_job[READY_DEPTH-1].valid;
    assign w_dispatch = (r_req_action == ACT_TICK) && (r_remaining == '0)
                      && w_job[0].valid;

    // The chain only moves in the update cycle, while busy is high.
    assign w_ctl.ins = r_busy && (r_req_action == ACT_ARRIVE) && !w_full;
    assign w_ctl.pop = r_busy && w_dispatch;

    // An arrival lands where the local compares of the cells turn true, and
    // the cells behind it shift one place back. A dispatch takes the head
    // cell and every cell shifts one place forward.
    genvar g;
    generate
        for (g = 0; g < READY_DEPTH; g++) begin : g_cell
            t_job w_prev_job;
            logic w_prev_before;
            t_job w_next_job;

            if (g == 0) begin : g_first
                assign w_prev_job    = JOB_EMPTY;
                assign w_prev_before = 1'b0;
            end else begin : g_mid
                assign w_prev_job    = w_job[g-1];
                assign w_prev_before = w_before[g-1];
            end

            if (g == READY_DEPTH - 1) begin : g_last
                assign w_next_job = JOB_EMPTY;
            end else begin : g_inner
                assign w_next_job = w_job[g+1];
            end

            sjfd_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_new         (w_new),
                .i_prev_job    (w_prev_job),
                .i_prev_before (w_prev_before),
                .i_next_job    (w_next_job),
                .o_job         (w_job[g]),
                .o_before      (w_before[g])
            );
        end
    endgenerate

    assign w_head_done = r_tick + {{(TIME_W-BURST_W){1'b0}}, w_job[0].data.burst};

    // Result and timekeeping for the request held in the update cycle.
    always_comb begin
        n_event     = EV_NONE;
        n_out_id    = '0;
        n_start     = '0;
        n_done      = '0;
        n_wait      = '0;
        n_turn      = '0;
        n_tick      = r_tick;
        n_remaining = r_remaining;
        unique case (r_req_action)
            ACT_ARRIVE: begin
                if (w_full) begin
                    n_event  = EV_DROP;
                    n_out_id = r_req_id;
                end
            end
            ACT_TICK: begin
                if (w_dispatch) begin
                    n_event     = EV_DISPATCH;
                    n_out_id    = w_job[0].data.id;
                    n_start     = r_tick;
                    n_done      = w_head_done;
                    n_wait      = r_tick - w_job[0].data.arrival;
                    n_turn      = w_head_done - w_job[0].data.arrival;
                    n_remaining = w_job[0].data.burst;
                end
                // The loaded burst already covers the tick that passes now.
                if (n_remaining != '0) begin
                    n_remaining = n_remaining - 1'b1;
                end
                n_tick = r_tick + 1'b1;
            end
            default: begin
                n_event = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b0;
            r_result_valid <= 1'b0;
            r_tick         <= '0;
            r_remaining    <= '0;
        end else begin
            r_busy         <= w_accept;
            r_result_valid <= r_busy;
            if (r_busy) begin
                r_tick      <= n_tick;
                r_remaining <= n_remaining;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_action <= i_action;
            r_req_id     <= i_job_id;
            r_req_burst  <= i_burst_length;
        end
        if (r_busy) begin
            r_event  <= n_event;
            r_out_id <= n_out_id;
            r_start  <= n_start;
            r_done   <= n_done;
            r_wait   <= n_wait;
            r_turn   <= n_turn;
        end
    end

    assign busy              = r_busy;
    assign o_result_valid    = r_result_valid;
    assign o_event_res       = r_event;
    assign o_out_job_id      = r_out_id;
    assign o_start_time      = r_start;
    assign o_completion_time = r_done;
    assign o_waiting_time    = r_wait;
    assign o_turnaround_time = r_turn;

endmodule

// File: rtl/core/sjfd_checker.sv
// Port-level checker for the shortest-job-first dispatcher, bound to its top.
// Depends on sjfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sjfd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_result_valid,
    input logic [sjfd_pkg::EVENT_W-1:0] o_event_res,
    input logic [sjfd_pkg::TIME_W-1:0]  o_start_time,
    input logic [sjfd_pkg::TIME_W-1:0]  o_completion_time,
    input logic [sjfd_pkg::TIME_W-1:0]  o_waiting_time,
    input logic [sjfd_pkg::TIME_W-1:0]  o_turnaround_time
);
    import sjfd_pkg::*;

    // A taken request occupies exactly one busy cycle, then gives its result.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_result_valid)
    `ASSERT_NEXT(a_busy_result, i_clk, i_rst_n, busy, o_result_valid && !busy)

    // Turnaround is waiting plus the service span of the same job.
    `ASSERT_IMPLY(a_turnaround, i_clk, i_rst_n,
        o_result_valid && (o_event_res == EV_DISPATCH),
        o_turnaround_time == (o_waiting_time + (o_completion_time - o_start_time)))

    // Drops and empty results carry no start, completion or waiting time.
    `ASSERT_IMPLY(a_no_times, i_clk, i_rst_n,
        o_result_valid && (o_event_res != EV_DISPATCH),
        (o_start_time == '0) && (o_completion_time == '0) && (o_waiting_time == '0))

endmodule

bind shortest_job_first_dispatcher_top sjfd_checker u_sjfd_checker (.*);
